// File: rtl/scv_pkg.sv
// Types and constants shared by the serial command valve PWM unit.
// No dependencies; the front end, back end, top level and testbench import this package.
package scv_pkg;

    localparam int DUTY_W      = 10;
    localparam int TIMEOUT_W   = 16;
    localparam int FRAME_BYTES = 5;
    localparam int IDX_W       = 3;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_ADDR_W-1:0] ADDR_TIMEOUT  = 2'd0;
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET = 16'd1172;

    localparam logic [7:0] CHAR_AT   = 8'h40;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_BANG = 8'h21;
    localparam logic [7:0] CHAR_S    = 8'h73;
    localparam logic [7:0] CHAR_E    = 8'h65;

    // Handshake stage: index of the last handshake byte.
    localparam logic [IDX_W-1:0] HS_LAST_IDX    = 3'd2;
    localparam logic [IDX_W-1:0] FRAME_LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    typedef enum logic [1:0] {
        PM_IDLE  = 2'd0,
        PM_HAND  = 2'd1,
        PM_FRAME = 2'd2
    } t_parse_mode;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_START   = 2'd1,
        EV_STOP    = 2'd2,
        EV_UNKNOWN = 2'd3
    } t_hs_event;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic      valve_one;
        logic      valve_two;
        logic      valve_three;
        logic      valve_four;
        logic      ack_send;
        t_hs_event handshake_event;
        logic      frame_loaded;
        logic      timed_out;
    } t_result;

    // Classified word passed from the front end to the back end.
    typedef struct packed {
        logic       is_tick;
        logic       is_at;
        logic       is_hash;
        logic       is_bang;
        logic       is_s;
        logic       is_e;
        logic [7:0] data;
    } t_cmd;

endpackage

// File: rtl/scv_queue.sv
// Small first-in first-out queue used between the stages of the unit.
// Depends on nothing but its type parameter.
module scv_queue #(
    parameter type t_data = logic [7:0],
    parameter int  DEPTH  = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_data i_wdata,
    output logic  o_full,
    input  logic  i_rd,
    output t_data o_rdata,
    output logic  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_data          r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/scv_front.sv
// Front end: accepts input words and classifies received bytes.
// Depends on scv_pkg.
module scv_front import scv_pkg::*; (
    input  logic     i_push,
    input  t_in_word i_word,
    output logic     o_full,
    input  logic     i_q_full,
    output logic     o_q_wr,
    output t_cmd     o_cmd
);

    assign o_full = i_q_full;
    assign o_q_wr = i_push && !i_q_full;

    always_comb begin
        o_cmd.is_tick = i_word.req_type;
        o_cmd.is_at   = (i_word.rx_byte == CHAR_AT);
        o_cmd.is_hash = (i_word.rx_byte == CHAR_HASH);
        o_cmd.is_bang = (i_word.rx_byte == CHAR_BANG);
        o_cmd.is_s    = (i_word.rx_byte == CHAR_S);
        o_cmd.is_e    = (i_word.rx_byte == CHAR_E);
        o_cmd.data    = i_word.rx_byte;
    end

endmodule

// File: rtl/scv_back.sv
// Back end: command parser, duty registers, timeout counter and PWM timebase.
// Depends on scv_pkg; fed from the command queue, writes the result queue.
module scv_back import scv_pkg::*; #(
    parameter int PERIOD_COUNTS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [TIMEOUT_W-1:0] i_timeout,
    input  t_cmd                 i_cmd,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_pop,
    input  logic                 i_res_full,
    output logic                 o_res_wr,
    output t_result              o_res
);

    localparam int PC_W  = $clog2(PERIOD_COUNTS);
    localparam int CMP_W = (PC_W > DUTY_W) ? PC_W : DUTY_W;

    t_parse_mode         r_mode, n_mode;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [7:0]          r_fb [4];
    logic [7:0]          n_fb [4];
    logic                r_hs_s, n_hs_s, r_hs_e, n_hs_e;
    logic [DUTY_W-1:0]   r_dn [4];
    logic [DUTY_W-1:0]   n_dn [4];
    logic [DUTY_W-1:0]   r_da [4];
    logic [DUTY_W-1:0]   n_da [4];
    logic [3:0]          r_lvl, n_lvl;
    logic [PC_W-1:0]     r_pc, n_pc;
    logic [TIMEOUT_W-1:0] r_idle, n_idle;
    logic                r_armed, n_armed;
    logic                proc, is_byte;
    t_hs_event           ev;
    logic                loaded;

    assign proc      = i_cmd_valid && !i_res_full;
    assign is_byte   = proc && !i_cmd.is_tick;
    assign o_cmd_pop = proc;
    assign o_res_wr  = proc;

    // Parser next state
    always_comb begin
        n_mode = r_mode;
        n_idx  = r_idx;
        if (is_byte) begin
            case (r_mode)
                PM_IDLE: begin
                    if (i_cmd.is_at) begin
                        n_mode = PM_HAND;
                        n_idx  = IDX_W'(1);
                    end else if (i_cmd.is_hash) begin
                        n_mode = PM_FRAME;
                        n_idx  = '0;
                    end
                end
                PM_HAND: begin
                    if (r_idx < HS_LAST_IDX) begin
                        n_idx = r_idx + 1'b1;
                    end else begin
                        // A closing '#' also opens a frame.
                        n_mode = i_cmd.is_hash ? PM_FRAME : PM_IDLE;
                        n_idx  = '0;
                    end
                end
                PM_FRAME: begin
                    if (r_idx < FRAME_LAST_IDX) begin
                        n_idx = r_idx + 1'b1;
                    end else begin
                        n_mode = PM_IDLE;
                        n_idx  = '0;
                    end
                end
                default: begin
                    n_mode = PM_IDLE;
                    n_idx  = '0;
                end
            endcase
        end
    end

    // Datapath and result
    always_comb begin
        n_fb    = r_fb;
        n_hs_s  = r_hs_s;
        n_hs_e  = r_hs_e;
        n_dn    = r_dn;
        n_da    = r_da;
        n_lvl   = r_lvl;
        n_pc    = r_pc;
        n_idle  = r_idle;
        n_armed = r_armed;
        ev      = EV_NONE;
        loaded  = 1'b0;
        if (is_byte) begin
            case (r_mode)
                PM_HAND: begin
                    if (r_idx < HS_LAST_IDX) begin
                        n_hs_s = i_cmd.is_s;
                        n_hs_e = i_cmd.is_e;
                    end else if (r_hs_s && i_cmd.is_bang) begin
                        ev      = EV_START;
                        n_armed = 1'b1;
                    end else if (r_hs_e && i_cmd.is_bang) begin
                        ev      = EV_STOP;
                        n_armed = 1'b0;
                        n_lvl   = '0;
                        for (int k = 0; k < 4; k++) begin
                            n_dn[k] = '0;
                            n_da[k] = '0;
                        end
                    end else begin
                        ev = EV_UNKNOWN;
                    end
                end
                PM_FRAME: begin
                    if (r_idx < FRAME_LAST_IDX) begin
                        n_fb[r_idx[1:0]] = i_cmd.data;
                    end else begin
                        n_dn[0] = {r_fb[0], r_fb[1][7:6]};
                        n_dn[1] = {r_fb[1][5:0], r_fb[2][7:4]};
                        n_dn[2] = {r_fb[2][3:0], r_fb[3][7:2]};
                        n_dn[3] = {r_fb[3][1:0], i_cmd.data};
                        n_idle  = '0;
                        loaded  = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end else if (proc) begin
            if (r_pc == '0) begin
                n_idle = (r_idle != '1) ? r_idle + 1'b1 : r_idle;
                for (int k = 0; k < 4; k++) begin
                    if (n_idle >= i_timeout) begin
                        n_dn[k] = '0;
                    end
                    n_da[k] = n_dn[k];
                end
            end
            for (int k = 0; k < 4; k++) begin
                n_lvl[k] = r_armed && (CMP_W'(r_pc) < CMP_W'(n_da[k]));
            end
            n_pc = (r_pc == PC_W'(PERIOD_COUNTS - 1)) ? '0 : r_pc + 1'b1;
        end

        o_res.valve_one       = n_lvl[0];
        o_res.valve_two       = n_lvl[1];
        o_res.valve_three     = n_lvl[2];
        o_res.valve_four      = n_lvl[3];
        o_res.ack_send        = !i_cmd.is_tick;
        o_res.handshake_event = ev;
        o_res.frame_loaded    = loaded;
        o_res.timed_out       = (n_idle >= i_timeout);
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_fb   <= n_fb;
            r_hs_s <= n_hs_s;
            r_hs_e <= n_hs_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= PM_IDLE;
            r_idx   <= '0;
            r_lvl   <= '0;
            r_pc    <= '0;
            r_idle  <= '0;
            r_armed <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_dn[k] <= '0;
                r_da[k] <= '0;
            end
        end else if (proc) begin
            r_mode  <= n_mode;
            r_idx   <= n_idx;
            r_lvl   <= n_lvl;
            r_pc    <= n_pc;
            r_idle  <= n_idle;
            r_armed <= n_armed;
            r_dn    <= n_dn;
            r_da    <= n_da;
        end
    end

endmodule

// File: rtl/serial_command_valve_pwm_unit.sv
// Serial command valve PWM unit: top level with configuration port and queues.
// A pushed word is registered in the command queue and its result in the result queue
// before it shows on the result ports; one word per cycle while neither queue is full.
// Reset is synchronous and active low: queues empty, parser idle, block disarmed,
// duties, period count and idle-period count zero, timeout register 1172.
// Depends on scv_pkg, scv_front, scv_queue and scv_back.
module serial_command_valve_pwm_unit import scv_pkg::*; #(
    parameter int PERIOD_COUNTS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input queue side
    input  logic                  push,
    output logic                  full,
    input  t_in_word              i_word,
    // Result queue side
    output logic                  empty,
    input  logic                  pop,
    output t_result               o_result,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // The front end classifies each word as it arrives and drops it into a
    // two-entry command queue. The back end takes one command per cycle
    // whenever the result queue has room, so both sides can stall
    // independently while a word still streams through every cycle.

    logic [TIMEOUT_W-1:0] r_timeout;
    t_cmd                 front_cmd, back_cmd;
    logic                 cmd_wr, cmd_full, cmd_empty, cmd_pop;
    logic                 res_wr, res_full;
    t_result              back_res;

    // The user must write the timeout register only while the block is idle; the block
    // does not enforce this, and the back end reads it directly.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TIMEOUT) ?
                    CFG_DATA_W'(r_timeout) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_TIMEOUT)) begin
            r_timeout <= pwdata[TIMEOUT_W-1:0];
        end
    end

    scv_front u_front (
        .i_push   (push),
        .i_word   (i_word),
        .o_full   (full),
        .i_q_full (cmd_full),
        .o_q_wr   (cmd_wr),
        .o_cmd    (front_cmd)
    );

    scv_queue #(
        .t_data (t_cmd),
        .DEPTH  (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_wdata (front_cmd),
        .o_full  (cmd_full),
        .i_rd    (cmd_pop),
        .o_rdata (back_cmd),
        .o_empty (cmd_empty)
    );

    scv_back #(
        .PERIOD_COUNTS (PERIOD_COUNTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_timeout   (r_timeout),
        .i_cmd       (back_cmd),
        .i_cmd_valid (!cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_wr    (res_wr),
        .o_res       (back_res)
    );

    // Result queue: the oldest result sits on the ports while it is not empty.
    scv_queue #(
        .t_data (t_result),
        .DEPTH  (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_wdata (back_res),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (o_result),
        .o_empty (empty)
    );

endmodule

// File: tb/serial_command_valve_pwm_unit_tb.sv
// Self-checking testbench for the serial command valve PWM unit.
// Holds a small scoreboard class that predicts and checks every result word.
// Depends on scv_pkg and serial_command_valve_pwm_unit.
`timescale 1ns / 100ps

import scv_pkg::*;

// Predicts the result word for every accepted input word and checks the words
// that come back from the block against the oldest prediction still waiting.
class valve_result_tracker;
    localparam int PERIOD_LEN = 1024;

    logic [TIMEOUT_W-1:0] timeout_limit;
    t_parse_mode          mode;
    logic [IDX_W-1:0]     idx;
    logic [7:0]           frame_buf [4];
    logic [7:0]           hs_buf [2];
    logic [DUTY_W-1:0]    duty_next [4];
    logic [DUTY_W-1:0]    duty_live [4];
    logic [DUTY_W-1:0]    count;
    logic [TIMEOUT_W-1:0] quiet_periods;
    logic                 armed;
    logic [3:0]           level;
    t_result              awaited_results [$];
    int                   errors;

    function new();
        timeout_limit = TIMEOUT_RESET;
        mode          = PM_IDLE;
        idx           = '0;
        count         = '0;
        quiet_periods = '0;
        armed         = 1'b0;
        level         = '0;
        errors        = 0;
        foreach (duty_next[k]) begin
            duty_next[k] = '0;
            duty_live[k] = '0;
            frame_buf[k] = '0;
        end
        hs_buf[0] = '0;
        hs_buf[1] = '0;
    endfunction

    function void set_limit(logic [TIMEOUT_W-1:0] limit);
        timeout_limit = limit;
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction

    function void note_word(t_in_word w);
        t_result   r;
        t_hs_event ev;
        logic      ack;
        logic      loaded;
        logic [7:0] b;
        b      = w.rx_byte;
        ev     = EV_NONE;
        ack    = 1'b0;
        loaded = 1'b0;
        if (!w.req_type) begin
            ack = 1'b1;
            case (mode)
                PM_IDLE: begin
                    if (b == CHAR_AT) begin
                        mode = PM_HAND;
                        idx  = 3'd1;
                    end else if (b == CHAR_HASH) begin
                        mode = PM_FRAME;
                        idx  = '0;
                    end
                end
                PM_HAND: begin
                    if (idx < HS_LAST_IDX) begin
                        hs_buf[idx[0]] = b;
                        idx = idx + 1'b1;
                    end else begin
                        if (hs_buf[1] == CHAR_S && b == CHAR_BANG) begin
                            ev    = EV_START;
                            armed = 1'b1;
                        end else if (hs_buf[1] == CHAR_E && b == CHAR_BANG) begin
                            ev    = EV_STOP;
                            armed = 1'b0;
                            level = '0;
                            foreach (duty_next[k]) begin
                                duty_next[k] = '0;
                                duty_live[k] = '0;
                            end
                        end else begin
                            ev = EV_UNKNOWN;
                        end
                        // A closing hash also opens a frame straight away.
                        mode = (b == CHAR_HASH) ? PM_FRAME : PM_IDLE;
                        idx  = '0;
                    end
                end
                default: begin
                    if (idx < FRAME_LAST_IDX) begin
                        frame_buf[idx[1:0]] = b;
                        idx = idx + 1'b1;
                    end else begin
                        duty_next[0]  = {frame_buf[0], frame_buf[1][7:6]};
                        duty_next[1]  = {frame_buf[1][5:0], frame_buf[2][7:4]};
                        duty_next[2]  = {frame_buf[2][3:0], frame_buf[3][7:2]};
                        duty_next[3]  = {frame_buf[3][1:0], b};
                        quiet_periods = '0;
                        loaded        = 1'b1;
                        mode          = PM_IDLE;
                        idx           = '0;
                    end
                end
            endcase
        end else begin
            if (count == '0) begin
                if (quiet_periods != '1)
                    quiet_periods = quiet_periods + 1'b1;
                if (quiet_periods >= timeout_limit)
                    foreach (duty_next[k]) duty_next[k] = '0;
                foreach (duty_live[k]) duty_live[k] = duty_next[k];
            end
            foreach (duty_live[k]) level[k] = armed && (count < duty_live[k]);
            count = (count == DUTY_W'(PERIOD_LEN - 1)) ? '0 : count + 1'b1;
        end
        r.valve_one       = level[0];
        r.valve_two       = level[1];
        r.valve_three     = level[2];
        r.valve_four      = level[3];
        r.ack_send        = ack;
        r.handshake_event = ev;
        r.frame_loaded    = loaded;
        r.timed_out       = (quiet_periods >= timeout_limit);
        awaited_results.push_back(r);
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (awaited_results.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("result word with nothing expected: %b", got);
            return;
        end
        want = awaited_results.pop_front();
        if (got !== want) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch: expected valves=%b%b%b%b ack=%b ev=%0d loaded=%b to=%b",
                         want.valve_one, want.valve_two, want.valve_three,
                         want.valve_four, want.ack_send, want.handshake_event,
                         want.frame_loaded, want.timed_out);
                $display("          got      valves=%b%b%b%b ack=%b ev=%0d loaded=%b to=%b",
                         got.valve_one, got.valve_two, got.valve_three,
                         got.valve_four, got.ack_send, got.handshake_event,
                         got.frame_loaded, got.timed_out);
            end
        end
    endfunction
endclass

module serial_command_valve_pwm_unit_tb;

    // The run is stopped by the watchdog if it ever gets this far.
    localparam int LIMIT_CYCLES = 400000;
    // Cycles allowed after the last expected word, to catch stray results.
    localparam int DRAIN_CYCLES = 16;
    // Both sides stop idling while their word counts lie in this window.
    localparam int CALM_FROM    = 700;
    localparam int CALM_TO      = 1000;
    // The receiver refuses every word for a while once this many have arrived.
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 300;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    t_in_word              i_word;
    logic                  empty;
    logic                  pop;
    t_result               o_result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    valve_result_tracker   tracker;
    int                    words_sent;
    int                    words_popped;
    int                    cycles;

    serial_command_valve_pwm_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_word   (i_word),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a word that never comes back ends here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Roughly one cycle in five is spent idle, except inside the calm window,
    // so that gaps land on every phase of the parser and of the PWM period.
    function automatic bit take_break(int n);
        return (n < CALM_FROM || n >= CALM_TO) && ($urandom_range(99) < 20);
    endfunction

    // Mostly random bytes, with the message markers and handshake letters
    // turning up often enough to hit the parser's corner cases.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return CHAR_AT;
            1:       return CHAR_HASH;
            2:       return CHAR_S;
            3:       return CHAR_E;
            4:       return CHAR_BANG;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Offers one word and waits for the edge at which the block takes it. Push
    // is left high on return, so that back-to-back words need no extra edge.
    task automatic send_word(t_in_word w);
        while (take_break(words_sent)) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (full);
        tracker.note_word(w);
        words_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        t_in_word w;
        w.req_type = 1'b0;
        w.rx_byte  = b;
        send_word(w);
    endtask

    // The byte field of a tick is junk; it is randomised to show it is ignored.
    task automatic send_tick();
        t_in_word w;
        w.req_type = 1'b1;
        w.rx_byte  = 8'($urandom_range(255));
        send_word(w);
    endtask

    task automatic send_hs(logic [7:0] second, logic [7:0] third);
        send_byte(CHAR_AT);
        send_byte(second);
        send_byte(third);
    endtask

    // The timeout register is only rewritten once every result has come back,
    // so the block is idle. The write is a setup cycle then an access cycle,
    // and a read of the same register follows to see the new value.
    task automatic change_timeout(logic [TIMEOUT_W-1:0] limit);
        push <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TIMEOUT;
        pwdata  <= CFG_DATA_W'(limit);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_limit(limit);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== CFG_DATA_W'(limit)) begin
            tracker.errors++;
            if (tracker.errors <= 10)
                $display("timeout read back: expected %0d, got %0d", limit, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_directed();
        // A stray byte outside any message is just acknowledged.
        send_byte(8'h5A);
        // A frame loads duties even while disarmed: 1023, 0, 1 and 2 counts.
        send_byte(CHAR_HASH);
        send_byte(8'hFF);
        send_byte(8'hC0);
        send_byte(8'h00);
        send_byte(8'h04);
        send_byte(8'h02);
        // Arm, then arm again while already armed.
        send_hs(CHAR_S, CHAR_BANG);
        send_hs(CHAR_S, CHAR_BANG);
        // The first tick starts a period and latches the duties.
        repeat (3) send_tick();
        // A handshake closed by a hash is unknown and also opens a frame whose
        // data bytes include the markers themselves.
        send_hs(CHAR_E, CHAR_HASH);
        send_byte(CHAR_AT);
        send_byte(CHAR_HASH);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hFF);
        // Stop drops the valves and clears every duty at once.
        send_hs(CHAR_E, CHAR_BANG);
    endtask

    // Mostly well-formed traffic (runs of ticks, frames, start and stop
    // handshakes) with broken handshakes, cut-short frames and noise mixed in.
    task automatic run_random(int n);
        int start;
        int r;
        start = words_sent;
        while (words_sent - start < n) begin
            r = $urandom_range(99);
            if (r < 55) begin
                repeat ($urandom_range(40, 1)) send_tick();
            end else if (r < 70) begin
                send_byte(CHAR_HASH);
                repeat (FRAME_BYTES) send_byte(pick_byte());
            end else if (r < 80) begin
                send_hs(CHAR_S, CHAR_BANG);
            end else if (r < 84) begin
                send_hs(CHAR_E, CHAR_BANG);
            end else if (r < 90) begin
                send_hs(pick_byte(), pick_byte());
            end else if (r < 95) begin
                send_byte(8'($urandom_range(255)));
            end else begin
                // A frame left short: whatever comes next is taken as its data.
                send_byte(CHAR_HASH);
                repeat ($urandom_range(FRAME_BYTES - 1, 1)) send_byte(pick_byte());
            end
        end
    endtask

    // Result side: pops at random, and once holds off for a long stretch while
    // the sender keeps offering words, so that the block fills and stalls.
    initial begin : result_sink
        bit held;
        held = 1'b0;
        pop <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!held && words_popped == HOLD_AT) begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            pop <= !take_break(words_popped);
            @(posedge i_clk);
            if (pop && !empty) begin
                tracker.check_result(o_result);
                words_popped++;
            end
        end
    end

    initial begin : stimulus
        tracker = new();
        i_rst_n <= 1'b0;
        push    <= 1'b0;
        i_word  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset timeout first, then the register's extremes and small values
        // that time out within the run; zero keeps the block timed out.
        run_directed();
        run_random(400);
        change_timeout(16'hFFFF);
        run_random(350);
        change_timeout(16'd1);
        run_random(300);
        change_timeout(16'd0);
        run_random(200);
        change_timeout(16'd2);
        run_random(400);
        push <= 1'b0;

        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
